[hw/rtl/tnf_pkg.sv]
// ============================================================================
// tnf_pkg
// Types and constants shared by the TLV node finder modules.
// ============================================================================
package tnf_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_TARGET_GROUP = 8'd0;
    localparam logic [7:0] CFG_TARGET_ITEM  = 8'd1;

    // Result kinds
    localparam logic RK_PAYLOAD = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    // Node types with a packed element size
    localparam logic [7:0] TYPE_HALF    = 8'd2;
    localparam logic [7:0] TYPE_QUAD_A  = 8'd3;
    localparam logic [7:0] TYPE_QUAD_B  = 8'd4;
    localparam logic [7:0] TYPE_OCTET_A = 8'd5;
    localparam logic [7:0] TYPE_OCTET_B = 8'd8;

    // Node header size in bytes
    localparam logic [31:0] HDR_BYTES = 32'd8;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic        node_found;
        logic [7:0]  node_type;
        logic [31:0] payload_length;
        logic [31:0] element_count;
        logic        truncated;
        logic        end_of_results;
    } t_out_item;

    // One classified byte handed from front to back
    typedef struct packed {
        logic        emit;
        logic [7:0]  payload_byte;
        logic        last;
        logic        found;
        logic [7:0]  node_type;
        logic [31:0] length;
        logic        truncated;
    } t_work;

endpackage

[hw/rtl/tnf_front.sv]
// ============================================================================
// tnf_front
// Event scanner: skips the prefix, walks the node header chain and marks
// payload bytes of the first matching node and the end of each event.
// ============================================================================
module tnf_front #(
    parameter int PREFIX_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tnf_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    input  logic [15:0]       i_target_group,
    input  logic [7:0]        i_target_item,
    output logic              o_in_stall,
    output logic              o_push,
    output tnf_pkg::t_work    o_work
);
    import tnf_pkg::*;

    localparam logic [2:0] PH_PREFIX  = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_PENDING = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_COPY    = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic [2:0]  START_PHASE = (PREFIX_BYTES == 0) ? PH_HEADER : PH_PREFIX;
    localparam logic [31:0] START_CNT   = (PREFIX_BYTES == 0) ? HDR_BYTES
                                                              : 32'(PREFIX_BYTES);

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [63:0] r_shift, n_shift;
    logic        r_found, n_found;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_len, n_len;
    logic        r_pend, n_pend;

    logic        accept;
    logic        emit;
    logic [31:0] cnt_dec;
    logic [63:0] shifted;
    logic [31:0] hdr_len;
    logic [31:0] len_m1;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    assign cnt_dec = (r_cnt != 32'd0) ? r_cnt - 32'd1 : r_cnt;
    assign shifted = {i_in_data.data_byte, r_shift[63:8]};
    assign hdr_len = r_shift[63:32];
    assign len_m1  = hdr_len - 32'd1;

    // Advance the scan by one byte
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_found = r_found;
        n_type  = r_type;
        n_len   = r_len;
        n_pend  = r_pend;
        emit    = 1'b0;
        unique case (r_phase) inside
            PH_PREFIX, PH_SKIP: begin
                n_cnt = cnt_dec;
                if (cnt_dec == 32'd0) begin
                    n_phase = PH_HEADER;
                    n_cnt   = HDR_BYTES;
                    n_shift = '0;
                end
            end
            PH_HEADER: begin
                n_shift = shifted;
                n_cnt   = cnt_dec;
                if (cnt_dec == 32'd0) begin
                    n_pend  = (shifted[15:0] == i_target_group) &&
                              (shifted[23:16] == i_target_item);
                    n_phase = PH_PENDING;
                end
            end
            PH_PENDING: begin
                if (r_pend) begin
                    n_found = 1'b1;
                    n_type  = r_shift[31:24];
                    n_len   = hdr_len;
                    n_pend  = 1'b0;
                    if (hdr_len == 32'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        emit    = 1'b1;
                        n_cnt   = len_m1;
                        n_phase = (len_m1 == 32'd0) ? PH_DONE : PH_COPY;
                    end
                end else if (hdr_len == 32'd0) begin
                    // Confirming byte opens the next header
                    n_phase = PH_HEADER;
                    n_shift = {i_in_data.data_byte, 56'd0};
                    n_cnt   = HDR_BYTES - 32'd1;
                end else begin
                    n_cnt = len_m1;
                    if (len_m1 == 32'd0) begin
                        n_phase = PH_HEADER;
                        n_cnt   = HDR_BYTES;
                        n_shift = '0;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_COPY: begin
                emit  = 1'b1;
                n_cnt = cnt_dec;
                if (cnt_dec == 32'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Build the work entry from the post-step state
    always_comb begin
        o_work.emit         = emit;
        o_work.payload_byte = i_in_data.data_byte;
        o_work.last         = i_in_data.last_byte;
        o_work.found        = n_found;
        o_work.node_type    = n_type;
        o_work.length       = n_len;
        o_work.truncated    = (n_phase == PH_COPY) && (n_cnt != 32'd0);
    end

    // Only bytes with results go to the queue
    assign o_push = accept && (emit || i_in_data.last_byte);

    // Hold scan state; restart at the end of each event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in_data.last_byte)) begin
            r_phase <= START_PHASE;
            r_cnt   <= START_CNT;
            r_shift <= '0;
            r_found <= 1'b0;
            r_type  <= '0;
            r_len   <= '0;
            r_pend  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_found <= n_found;
            r_type  <= n_type;
            r_len   <= n_len;
            r_pend  <= n_pend;
        end
    end

endmodule

[hw/rtl/tnf_queue.sv]
// ============================================================================
// tnf_queue
// Short show-ahead queue of work entries between front and back.
// ============================================================================
module tnf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tnf_pkg::t_work i_work,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tnf_pkg::t_work o_head
);
    import tnf_pkg::*;

    t_work              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/tnf_back.sv]
// ============================================================================
// tnf_back
// Result stage: turns each work entry into a payload beat, a summary beat
// or both, and holds them in an output register.
// ============================================================================
module tnf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  tnf_pkg::t_work     i_head,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output tnf_pkg::t_out_item o_out_data
);
    import tnf_pkg::*;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      r_half, n_half;
    logic      load;
    logic [31:0] elems;

    assign load = !r_out_valid || !i_out_stall;

    // Element count from the type's element size
    always_comb begin
        case (i_head.node_type) inside
            TYPE_HALF:                  elems = {1'b0, i_head.length[31:1]};
            TYPE_QUAD_A, TYPE_QUAD_B:   elems = {2'b0, i_head.length[31:2]};
            TYPE_OCTET_A, TYPE_OCTET_B: elems = {3'b0, i_head.length[31:3]};
            default:                    elems = i_head.length;
        endcase
    end

    // Pick the next beat; pop once the entry is fully sent
    always_comb begin
        o_pop       = 1'b0;
        n_half      = r_half;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (load && i_q_valid) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (i_head.emit && !r_half) begin
                n_out.result_kind    = RK_PAYLOAD;
                n_out.payload_byte   = i_head.payload_byte;
                n_out.end_of_results = !i_head.last;
                if (i_head.last) begin
                    n_half = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_out.result_kind    = RK_SUMMARY;
                n_out.end_of_results = 1'b1;
                if (i_head.found) begin
                    n_out.node_found     = 1'b1;
                    n_out.node_type      = i_head.node_type;
                    n_out.payload_length = i_head.length;
                    n_out.element_count  = elems;
                    n_out.truncated      = i_head.truncated;
                end
                o_pop  = 1'b1;
                n_half = 1'b0;
            end
        end
    end

    // Hold the output beat while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_half      <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/tlv_node_finder.sv]
// ============================================================================
// tlv_node_finder
// Searches a byte-serial event for the first node header matching a target
// group and item, copies its payload out and ends each event with a summary.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one event byte
//   per beat, with last_byte set on the final byte of the event. One byte is
//   taken every cycle while the four-entry work queue has room.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives payload
//   beats of the matching node and one summary beat per event. A byte that
//   is both the final payload byte and the event end gives two beats, which
//   the queue absorbs. A byte's first result passes the scanner, the queue
//   and then the output register, where it is held while the receiver stalls.
//   Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; index 0 writes target_group, index 1 target_item, others
//   are dropped. Targets are sampled when a header's eighth byte arrives.
//   Reset clears the targets, empties the queue and restarts the scan at the
//   prefix, or at the header if PREFIX_BYTES is 0. When the receiver stalls,
//   the output beat holds, the queue fills and then o_in_stall rises.
module tlv_node_finder #(
    parameter int PREFIX_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tnf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tnf_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import tnf_pkg::*;

    logic [15:0] r_target_group;
    logic [7:0]  r_target_item;

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_work push_work;
    t_work head_work;

    assign o_cfg_ready = 1'b1;

    // Write target registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_group <= '0;
            r_target_item  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_GROUP: r_target_group <= i_cfg_data;
                CFG_TARGET_ITEM:  r_target_item  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tnf_front #(
        .PREFIX_BYTES(PREFIX_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_data      (i_in_data),
        .i_q_full       (q_full),
        .i_target_group (r_target_group),
        .i_target_item  (r_target_item),
        .o_in_stall     (o_in_stall),
        .o_push         (push),
        .o_work         (push_work)
    );

    tnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_work)
    );

    tnf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head_work),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
